[sv/hcb_pkg.sv]
// Shared types for the Huffman code builder: controller states, commands and status.
package hcb_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_LEAF_RD,
        ST_LEAF_CHK,
        ST_LEAF_END,
        ST_MERGE_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_KILL_A,
        ST_KILL_B,
        ST_NEW,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_OUT,
        ST_POP_RD,
        ST_POP_LD
    } t_state;

    typedef enum logic {
        PH_COUNT,
        PH_WALK
    } t_phase;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic cnt_rd;
        logic cnt_wr;
        logic cnt_clr;
        logic leaf_init;
        logic leaf_rd;
        logic leaf_chk;
        logic leaf_end;
        logic scan_init;
        logic scan_rd;
        logic scan_chk;
        logic kill_a;
        logic kill_b;
        logic new_node;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic out_empty;
        logic pop_rd;
        logic pop_ld;
    } t_cmd;

    typedef struct packed {
        logic cnt_ok;
        logic leaf_last;
        logic alive_zero;
        logic alive_one;
        logic scan_last;
        logic is_leaf;
        logic res_last;
    } t_sts;

endpackage

[sv/huffman_code_builder.sv]
// Top level of the Huffman code builder: stream ports around controller and datapath.
//
//  channel  | direction | tdata                                  | tuser      | tlast
//  s_axis   | in        | symbol                                 | op         | -
//  m_axis   | out       | code_symbol, code_bits, code_length    | valid_res  | last_entry
//
// A count word is a histogram read, then a write back; a count that is ignored
// writes nothing. The first fetch builds the tree: a leaf scan over the alphabet
// entries, then per merge a scan of every node, the two kills and the new node. Each
// fetch then walks down to the next leaf level by level and, unless the word was the
// last, pops the stack after it leaves. Reset is synchronous and clears the histogram at once.
// Input is held off while a result word waits for the consumer.
module huffman_code_builder #(
    parameter int ALPHABET     = 256,
    parameter int COUNT_WIDTH  = 24,
    parameter int MAX_CODE_LEN = 48,
    localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1),
    localparam int OUT_W       = ((8 + MAX_CODE_LEN + LEN_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,  // symbol
    input  logic             i_s_axis_tuser,  // op
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,  // code_symbol, code_bits, code_length
    output logic             o_m_axis_tuser,  // valid_res
    output logic             o_m_axis_tlast   // last_entry
);
    hcb_pkg::t_cmd cmd;
    hcb_pkg::t_sts sts;
    logic [7:0]              res_sym;
    logic [MAX_CODE_LEN-1:0] res_code;
    logic [LEN_W-1:0]        res_len;

    hcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_op     (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hcb_dp #(
        .ALPHABET     (ALPHABET),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_symbol    (i_s_axis_tdata),
        .o_res_valid (o_m_axis_tuser),
        .o_res_sym   (res_sym),
        .o_res_code  (res_code),
        .o_res_len   (res_len),
        .o_res_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'({res_len, res_code, res_sym});

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input accepted while a result word is pending");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("empty-text word without last flag");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> o_s_axis_tready)
        else $error("block not ready after the final word");

endmodule

[sv/hcb_dp.sv]
// Datapath of the Huffman code builder: histogram, node store, merge search and tree walk.
module hcb_dp #(
    parameter int ALPHABET     = 256,
    parameter int COUNT_WIDTH  = 24,
    parameter int MAX_CODE_LEN = 48,
    localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hcb_pkg::t_cmd           i_cmd,
    output hcb_pkg::t_sts           o_sts,
    input  logic [7:0]              i_symbol,
    output logic                    o_res_valid,
    output logic [7:0]              o_res_sym,
    output logic [MAX_CODE_LEN-1:0] o_res_code,
    output logic [LEN_W-1:0]        o_res_len,
    output logic                    o_res_last
);
    localparam int CI_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int NODE_N = 2 * ALPHABET - 1;
    localparam int NODE_W = $clog2(NODE_N);
    localparam int WW     = COUNT_WIDTH + 1;
    localparam int CW     = MAX_CODE_LEN;
    localparam logic [NODE_W-1:0] NO_CHILD = '1;

    logic [COUNT_WIDTH-1:0] r_cnt_mem [ALPHABET];
    logic [ALPHABET-1:0]    r_cnt_vld;
    logic [COUNT_WIDTH-1:0] r_cnt_rd;
    logic                   r_cnt_rd_vld;
    logic [CI_W-1:0]        r_sym;
    logic [CI_W-1:0]        r_s;
    logic [CI_W-1:0]        cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_val;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    logic [WW-1:0]     r_w_mem     [NODE_N];
    logic              r_alive_mem [NODE_N];
    logic [NODE_W-1:0] r_left_mem  [NODE_N];
    logic [NODE_W-1:0] r_right_mem [NODE_N];
    logic [CI_W-1:0]   r_sym_mem   [NODE_N];
    logic [WW-1:0]     r_nd_w;
    logic              r_nd_alive;
    logic [NODE_W-1:0] r_nd_left;
    logic [NODE_W-1:0] r_nd_right;
    logic [CI_W-1:0]   r_nd_sym;

    logic [NODE_W-1:0] r_nodes;
    logic [NODE_W-1:0] r_nleaf;
    logic [NODE_W-1:0] r_alive;
    logic [NODE_W-1:0] r_k;
    logic [NODE_W-1:0] r_idx;
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic [WW-1:0]     r_wa;
    logic [WW-1:0]     r_wb;
    logic              r_have_a;
    logic              r_have_b;
    logic [NODE_W-1:0] merged;
    logic [NODE_W-1:0] scan_idx;
    logic [NODE_W-1:0] nd_raddr;
    logic              nd_we;
    logic [WW-1:0]     nd_w;
    logic [NODE_W-1:0] nd_left;
    logic [NODE_W-1:0] nd_right;
    logic              al_we;
    logic [NODE_W-1:0] al_addr;
    logic              al_data;
    logic [WW:0]       wsum;
    logic [WW-1:0]     wsat;

    logic [NODE_W-1:0] r_stk_node [ALPHABET];
    logic [CW-1:0]     r_stk_code [ALPHABET];
    logic [LEN_W-1:0]  r_stk_len  [ALPHABET];
    logic [NODE_W-1:0] r_pop_node;
    logic [CW-1:0]     r_pop_code;
    logic [LEN_W-1:0]  r_pop_len;
    logic [CI_W-1:0]   r_sp;
    logic [NODE_W-1:0] r_cur;
    logic [CW-1:0]     r_code;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  next_len;
    logic [CW-1:0]     code0;
    logic [CW-1:0]     code1;

    logic              r_res_valid;
    logic [7:0]        r_res_sym;
    logic [CW-1:0]     r_res_code;
    logic [LEN_W-1:0]  r_res_len;
    logic              r_res_last;

    // Histogram with one valid bit per entry; an entry that is not valid reads as zero.
    assign cnt_raddr = i_cmd.cnt_rd ? i_symbol[CI_W-1:0] : r_s;
    assign cnt_val   = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign cnt_inc   = (cnt_val == '1) ? cnt_val : cnt_val + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_rd || i_cmd.leaf_rd) begin
            r_cnt_rd     <= r_cnt_mem[cnt_raddr];
            r_cnt_rd_vld <= r_cnt_vld[cnt_raddr];
        end
        if (i_cmd.cnt_wr) begin
            r_cnt_mem[r_sym] <= cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_cnt_vld <= '0;
        end else if (i_cmd.cnt_wr) begin
            r_cnt_vld[r_sym] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_rd) begin
            r_sym <= i_symbol[CI_W-1:0];
        end
    end

    // The live list is the merged nodes newest first, then the leaves in creation order.
    assign merged   = r_nodes - r_nleaf;
    assign scan_idx = (r_k < merged) ? r_nodes - 1'b1 - r_k : r_k - merged;
    assign nd_raddr = i_cmd.scan_rd ? scan_idx : r_cur;
    assign wsum     = {1'b0, r_wa} + {1'b0, r_wb};
    assign wsat     = wsum[WW] ? '1 : wsum[WW-1:0];

    always_comb begin
        nd_we    = 1'b0;
        nd_w     = {1'b0, cnt_val};
        nd_left  = NO_CHILD;
        nd_right = NO_CHILD;
        al_we    = 1'b0;
        al_addr  = r_nodes;
        al_data  = 1'b1;
        if (i_cmd.leaf_chk && (cnt_val != '0)) begin
            nd_we = 1'b1;
            al_we = 1'b1;
        end
        if (i_cmd.new_node) begin
            nd_we    = 1'b1;
            nd_w     = wsat;
            nd_left  = r_a;
            nd_right = r_b;
            al_we    = 1'b1;
        end
        if (i_cmd.kill_a) begin
            al_we   = 1'b1;
            al_addr = r_a;
            al_data = 1'b0;
        end
        if (i_cmd.kill_b) begin
            al_we   = 1'b1;
            al_addr = r_b;
            al_data = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            r_w_mem[r_nodes]     <= nd_w;
            r_left_mem[r_nodes]  <= nd_left;
            r_right_mem[r_nodes] <= nd_right;
            r_sym_mem[r_nodes]   <= r_s;
        end
        if (al_we) begin
            r_alive_mem[al_addr] <= al_data;
        end
        if (i_cmd.scan_rd || i_cmd.walk_rd) begin
            r_nd_w     <= r_w_mem[nd_raddr];
            r_nd_alive <= r_alive_mem[nd_raddr];
            r_nd_left  <= r_left_mem[nd_raddr];
            r_nd_right <= r_right_mem[nd_raddr];
            r_nd_sym   <= r_sym_mem[nd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.leaf_init) begin
            r_s     <= CI_W'(ALPHABET - 1);
            r_nodes <= '0;
        end else begin
            if (i_cmd.leaf_chk) begin
                r_s <= r_s - 1'b1;
            end
            if ((nd_we && i_cmd.leaf_chk) || i_cmd.new_node) begin
                r_nodes <= r_nodes + 1'b1;
            end
        end
        if (i_cmd.leaf_end) begin
            r_nleaf <= r_nodes;
            r_alive <= r_nodes;
        end else if (i_cmd.new_node) begin
            r_alive <= r_alive - 1'b1;
        end
        if (i_cmd.scan_rd) begin
            r_idx <= scan_idx;
        end
    end

    // Two smallest in list order; ties keep the earlier node.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_k      <= '0;
            r_have_a <= 1'b0;
            r_have_b <= 1'b0;
        end else if (i_cmd.scan_chk) begin
            r_k <= r_k + 1'b1;
            if (r_nd_alive) begin
                if (!r_have_a || (r_nd_w < r_wa)) begin
                    r_b      <= r_a;
                    r_wb     <= r_wa;
                    r_have_b <= r_have_a;
                    r_a      <= r_idx;
                    r_wa     <= r_nd_w;
                    r_have_a <= 1'b1;
                end else if (!r_have_b || (r_nd_w < r_wb)) begin
                    r_b      <= r_idx;
                    r_wb     <= r_nd_w;
                    r_have_b <= 1'b1;
                end
            end
        end
    end

    // Depth-first walk: descend right, keep the left branch on the stack.
    assign next_len = (r_len < LEN_W'(MAX_CODE_LEN)) ? r_len + 1'b1 : r_len;
    assign code0    = r_code << 1;
    assign code1    = (r_code << 1) | CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && (r_nd_left != NO_CHILD)) begin
            r_stk_node[r_sp] <= r_nd_left;
            r_stk_code[r_sp] <= code1;
            r_stk_len[r_sp]  <= next_len;
        end
        if (i_cmd.pop_rd) begin
            r_pop_node <= r_stk_node[r_sp - 1'b1];
            r_pop_code <= r_stk_code[r_sp - 1'b1];
            r_pop_len  <= r_stk_len[r_sp - 1'b1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_cur  <= r_nodes - 1'b1;
            r_code <= '0;
            r_len  <= '0;
            r_sp   <= '0;
        end else if (i_cmd.walk_step && (r_nd_left != NO_CHILD)) begin
            r_sp   <= r_sp + 1'b1;
            r_cur  <= r_nd_right;
            r_code <= code0;
            r_len  <= next_len;
        end else if (i_cmd.pop_rd) begin
            r_sp <= r_sp - 1'b1;
        end else if (i_cmd.pop_ld) begin
            r_cur  <= r_pop_node;
            r_code <= r_pop_code;
            r_len  <= r_pop_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_empty) begin
            r_res_valid <= 1'b0;
            r_res_sym   <= '0;
            r_res_code  <= '0;
            r_res_len   <= '0;
            r_res_last  <= 1'b1;
        end else if (i_cmd.walk_step && (r_nd_left == NO_CHILD)) begin
            r_res_valid <= 1'b1;
            r_res_sym   <= 8'(r_nd_sym);
            r_res_code  <= r_code;
            r_res_len   <= r_len;
            r_res_last  <= (r_sp == '0);
        end
    end

    assign o_sts.cnt_ok     = (9'(i_symbol) < 9'(ALPHABET));
    assign o_sts.leaf_last  = (r_s == '0);
    assign o_sts.alive_zero = (r_alive == '0);
    assign o_sts.alive_one  = (r_alive == NODE_W'(1));
    assign o_sts.scan_last  = (r_k == r_nodes - 1'b1);
    assign o_sts.is_leaf    = (r_nd_left == NO_CHILD);
    assign o_sts.res_last   = r_res_last;

    assign o_res_valid = r_res_valid;
    assign o_res_sym   = r_res_sym;
    assign o_res_code  = r_res_code;
    assign o_res_len   = r_res_len;
    assign o_res_last  = r_res_last;

endmodule

[sv/hcb_ctrl.sv]
// Controller state machine of the Huffman code builder.
module hcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  hcb_pkg::t_sts i_sts,
    output hcb_pkg::t_cmd o_cmd
);
    hcb_pkg::t_state r_state;
    hcb_pkg::t_state n_state;
    hcb_pkg::t_phase r_phase;
    hcb_pkg::t_phase n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::ST_IDLE;
            r_phase <= hcb_pkg::PH_COUNT;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            hcb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == hcb_pkg::OP_COUNT) begin
                        if (r_phase == hcb_pkg::PH_COUNT && i_sts.cnt_ok) begin
                            o_cmd.cnt_rd = 1'b1;
                            n_state      = hcb_pkg::ST_CNT_WR;
                        end
                    end else if (r_phase == hcb_pkg::PH_COUNT) begin
                        o_cmd.leaf_init = 1'b1;
                        n_state         = hcb_pkg::ST_LEAF_RD;
                    end else begin
                        n_state = hcb_pkg::ST_WALK_RD;
                    end
                end
            end
            hcb_pkg::ST_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = hcb_pkg::ST_IDLE;
            end
            hcb_pkg::ST_LEAF_RD: begin
                o_cmd.leaf_rd = 1'b1;
                n_state       = hcb_pkg::ST_LEAF_CHK;
            end
            hcb_pkg::ST_LEAF_CHK: begin
                o_cmd.leaf_chk = 1'b1;
                n_state = i_sts.leaf_last ? hcb_pkg::ST_LEAF_END : hcb_pkg::ST_LEAF_RD;
            end
            hcb_pkg::ST_LEAF_END: begin
                o_cmd.leaf_end = 1'b1;
                n_state        = hcb_pkg::ST_MERGE_CHK;
            end
            hcb_pkg::ST_MERGE_CHK: begin
                if (i_sts.alive_zero) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = hcb_pkg::ST_OUT;
                end else if (i_sts.alive_one) begin
                    o_cmd.walk_init = 1'b1;
                    n_phase         = hcb_pkg::PH_WALK;
                    n_state         = hcb_pkg::ST_WALK_RD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = hcb_pkg::ST_SCAN_RD;
                end
            end
            hcb_pkg::ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = hcb_pkg::ST_SCAN_CHK;
            end
            hcb_pkg::ST_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = i_sts.scan_last ? hcb_pkg::ST_KILL_A : hcb_pkg::ST_SCAN_RD;
            end
            hcb_pkg::ST_KILL_A: begin
                o_cmd.kill_a = 1'b1;
                n_state      = hcb_pkg::ST_KILL_B;
            end
            hcb_pkg::ST_KILL_B: begin
                o_cmd.kill_b = 1'b1;
                n_state      = hcb_pkg::ST_NEW;
            end
            hcb_pkg::ST_NEW: begin
                o_cmd.new_node = 1'b1;
                n_state        = hcb_pkg::ST_MERGE_CHK;
            end
            hcb_pkg::ST_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = hcb_pkg::ST_WALK_CHK;
            end
            hcb_pkg::ST_WALK_CHK: begin
                o_cmd.walk_step = 1'b1;
                n_state = i_sts.is_leaf ? hcb_pkg::ST_OUT : hcb_pkg::ST_WALK_RD;
            end
            hcb_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.res_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_phase       = hcb_pkg::PH_COUNT;
                        n_state       = hcb_pkg::ST_IDLE;
                    end else begin
                        n_state = hcb_pkg::ST_POP_RD;
                    end
                end
            end
            hcb_pkg::ST_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = hcb_pkg::ST_POP_LD;
            end
            hcb_pkg::ST_POP_LD: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = hcb_pkg::ST_IDLE;
            end
            default: begin
                n_state = hcb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[bench/hcb_checker.sv]
// Checker for the Huffman code builder: predicts each result word and compares it.
module hcb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending
);

    localparam int  NODE_MAX = 511;
    localparam int  NO_CHILD = 511;
    localparam longint CNT_MAX = (64'd1 << 24) - 1;
    localparam longint WT_MAX  = (64'd1 << 25) - 1;

    typedef struct packed {
        logic        vld;
        logic [7:0]  sym;
        logic [47:0] bits;
        logic [5:0]  len;
        logic        last;
    } t_code_word;

    t_code_word  code_words_due[$];
    longint      hist[256];
    longint      weight[NODE_MAX];
    int          left_of[NODE_MAX];
    int          right_of[NODE_MAX];
    int          sym_of[NODE_MAX];
    int          work_list[257];
    int          work_len;
    hcb_pkg::t_phase phase;
    logic [7:0]  leaf_sym[256];
    logic [47:0] leaf_bits[256];
    int          leaf_len[256];
    int          leaf_total;
    int          leaf_pos;

    function automatic int pull_lightest();
        int best;
        int node;
        best = 0;
        for (int i = 1; i < work_len; i++) begin
            if (weight[work_list[i]] < weight[work_list[best]]) begin
                best = i;
            end
        end
        node = work_list[best];
        for (int i = best; i + 1 < work_len; i++) begin
            work_list[i] = work_list[i + 1];
        end
        work_len--;
        return node;
    endfunction

    function automatic void build_tree();
        int          nodes;
        int          a;
        int          b;
        longint      w;
        int          stk_node[$];
        logic [47:0] stk_bits[$];
        int          stk_len[$];
        int          n;
        logic [47:0] c;
        int          l;
        int          nl;
        nodes    = 0;
        work_len = 0;
        for (int s = 255; s >= 0; s--) begin
            if (hist[s] > 0) begin
                weight[nodes]   = hist[s];
                left_of[nodes]  = NO_CHILD;
                right_of[nodes] = NO_CHILD;
                sym_of[nodes]   = s;
                work_list[work_len++] = nodes;
                nodes++;
            end
        end
        while (work_len > 1 && nodes < NODE_MAX) begin
            a = pull_lightest();
            b = pull_lightest();
            w = weight[a] + weight[b];
            weight[nodes]   = (w > WT_MAX) ? WT_MAX : w;
            left_of[nodes]  = a;
            right_of[nodes] = b;
            sym_of[nodes]   = 0;
            for (int i = work_len; i > 0; i--) begin
                work_list[i] = work_list[i - 1];
            end
            work_list[0] = nodes;
            work_len++;
            nodes++;
        end
        leaf_total = 0;
        leaf_pos   = 0;
        if (work_len > 0) begin
            stk_node.push_back(work_list[0]);
            stk_bits.push_back('0);
            stk_len.push_back(0);
        end
        while (stk_node.size() > 0) begin
            n = stk_node.pop_back();
            c = stk_bits.pop_back();
            l = stk_len.pop_back();
            if (left_of[n] == NO_CHILD) begin
                if (leaf_total < 256) begin
                    leaf_sym[leaf_total]  = sym_of[n][7:0];
                    leaf_bits[leaf_total] = c;
                    leaf_len[leaf_total]  = l;
                    leaf_total++;
                end
            end else begin
                nl = (l < 48) ? l + 1 : 48;
                stk_node.push_back(left_of[n]);
                stk_bits.push_back({c[46:0], 1'b1});
                stk_len.push_back(nl);
                stk_node.push_back(right_of[n]);
                stk_bits.push_back({c[46:0], 1'b0});
                stk_len.push_back(nl);
            end
        end
    endfunction

    function automatic void predict_word(logic op, logic [7:0] sym);
        t_code_word e;
        if (op == hcb_pkg::OP_COUNT) begin
            if (phase == hcb_pkg::PH_COUNT && hist[sym] < CNT_MAX) begin
                hist[sym]++;
            end
            return;
        end
        if (phase == hcb_pkg::PH_COUNT) begin
            build_tree();
            if (leaf_total == 0) begin
                e = '{1'b0, 8'd0, 48'd0, 6'd0, 1'b1};
                code_words_due.push_back(e);
                return;
            end
            phase = hcb_pkg::PH_WALK;
        end
        e.vld  = 1'b1;
        e.sym  = leaf_sym[leaf_pos];
        e.bits = leaf_bits[leaf_pos];
        e.len  = leaf_len[leaf_pos][5:0];
        leaf_pos++;
        e.last = (leaf_pos >= leaf_total);
        if (e.last) begin
            foreach (hist[i]) hist[i] = 0;
            phase    = hcb_pkg::PH_COUNT;
            leaf_pos = 0;
        end
        code_words_due.push_back(e);
    endfunction

    always @(posedge i_clk) begin
        t_code_word e;
        t_code_word got;
        if (!i_rst_n) begin
            foreach (hist[i]) hist[i] = 0;
            phase      = hcb_pkg::PH_COUNT;
            leaf_total = 0;
            leaf_pos   = 0;
            work_len   = 0;
            code_words_due.delete();
            o_errors  <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tuser, i_m_tdata[7:0], i_m_tdata[55:8], i_m_tdata[61:56], i_m_tlast};
                if (code_words_due.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("unexpected word: vld=%0d sym=%0d bits=%h len=%0d last=%0d",
                                 got.vld, got.sym, got.bits, got.len, got.last);
                    end
                    o_errors <= o_errors + 1;
                end else begin
                    e = code_words_due.pop_front();
                    if (got != e) begin
                        if (o_errors < 10) begin
                            $display("mismatch: exp vld=%0d sym=%0d bits=%h len=%0d last=%0d",
                                     e.vld, e.sym, e.bits, e.len, e.last);
                            $display("          got vld=%0d sym=%0d bits=%h len=%0d last=%0d",
                                     got.vld, got.sym, got.bits, got.len, got.last);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_word(i_s_tuser, i_s_tdata);
            end
        end
        o_pending <= code_words_due.size();
    end

endmodule

[bench/testbench.sv]
// Testbench top for the Huffman code builder: stimulus, consumer stalls and verdict.
module testbench;

    localparam int LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = hcb_pkg::OP_COUNT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          stall = 0;
    int          words_sent = 0;
    bit          burst = 0;
    bit          seen[256];
    int          distinct = 0;
    bit          walking = 0;

    huffman_code_builder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast)
    );

    hcb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall > 0) begin
            stall    <= stall - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (burst || $urandom_range(0, 1)) begin
                m_tready <= 1'b1;
            end else begin
                stall    <= $urandom_range(1, 8);
                m_tready <= 1'b0;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(logic op, logic [7:0] sym);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= sym;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic count_symbol(logic [7:0] sym);
        send_word(hcb_pkg::OP_COUNT, sym);
        if (!walking && !seen[sym]) begin
            seen[sym] = 1;
            distinct++;
        end
    endtask

    // Fetches every code word of the current text; count words mixed in are ignored.
    task automatic fetch_all(bit noisy);
        int n;
        n = (distinct == 0) ? 1 : distinct;
        walking = (distinct > 1);
        for (int i = 0; i < n; i++) begin
            send_word(hcb_pkg::OP_FETCH, 8'($urandom));
            if (noisy && i + 1 < n && $urandom_range(0, 3) == 0) begin
                count_symbol(8'($urandom));
            end
        end
        walking  = 0;
        distinct = 0;
        foreach (seen[i]) seen[i] = 0;
    endtask

    initial begin
        int len;
        int base;
        int span;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fetch_all(0);
        repeat (3) count_symbol(8'd255);
        fetch_all(0);
        count_symbol(8'd0);
        count_symbol(8'd255);
        fetch_all(0);
        count_symbol(8'hAA);
        count_symbol(8'h55);
        repeat (2) count_symbol(8'h01);
        repeat (4) count_symbol(8'h80);
        count_symbol(8'h7F);
        fetch_all(1);
        fetch_all(0);

        while (words_sent < 1150) begin
            burst = ($urandom_range(0, 4) == 0);
            if (words_sent + 520 < 1150 && $urandom_range(0, 30) == 0) begin
                foreach (seen[i]) count_symbol(8'(i));
            end else begin
                len  = $urandom_range(1, 40);
                span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 8);
                base = $urandom_range(0, 255);
                for (int i = 0; i < len; i++) begin
                    count_symbol(8'(base + $urandom_range(0, span - 1)));
                end
            end
            fetch_all($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                fetch_all(0);
            end
        end
        burst = 0;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
